[design/kbi_pkg.sv]
package kbi_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int KEYWORDS_DEF = 64;
	localparam int ID_BITS_DEF  = 16;

	localparam int ID_W     = 16;
	localparam int KW_W     = 64;
	localparam int KEY_W    = 6;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ID_W-1:0]  entry_id;
		logic [KW_W-1:0]  keyword_bits;
		logic [KEY_W-1:0] keyword;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]     match_id;
		logic                found;
		logic                last;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_REMOVE,
		ST_QUERY
	} state_t;

endpackage

[design/keyword_bitmap_index.sv]
// Channel  | Handshake                 | Payload
// command  | start, busy (taken: start & !busy) | cmd    (kbi_pkg::cmd_t)
// result   | result_valid, one cycle   | result (kbi_pkg::rsp_t)
//
// Entries sit in one table memory sorted by id (stable among equal ids), n = fill count.
// Insert, remove and query each walk the table once through its single read port,
// one slot per cycle.
// Insert into a full table and unused op codes answer without a walk, in the cycle after the transfer.
// Reset empties the table at once (fill count to zero); no clearing pass.
// Results cannot be held off; a query delivers at most one match per cycle.
module keyword_bitmap_index #(
	parameter int CAPACITY = kbi_pkg::CAPACITY_DEF,
	parameter int KEYWORDS = kbi_pkg::KEYWORDS_DEF,
	parameter int ID_BITS  = kbi_pkg::ID_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kbi_pkg::cmd_t cmd,
	output logic          busy,
	output logic          result_valid,
	output kbi_pkg::rsp_t result
);

	import kbi_pkg::*;

	localparam int IW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam int EW = IW + KEYWORDS;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] ptr_m1;
	logic flag_q, flag_d;
	logic prev_q, prev_d;
	logic [IW-1:0] pend_q, pend_d;
	logic [IW-1:0] id_q, id_d;
	logic [KEYWORDS-1:0] bm_q, bm_d;
	logic [KEY_W-1:0] kw_q, kw_d;

	logic rd_vld_s1;
	logic [AW-1:0] addr_s1;

	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data, rd_data;
	logic [IW-1:0] rd_id;
	logic [KEYWORDS-1:0] rd_bm;
	logic [KW_W-1:0] rd_bm_ext;
	logic kw_hit;

	logic rsp_vld_d;
	rsp_t rsp_d;
	logic result_valid_q;
	rsp_t result_q;

	kbi_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(EW)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_id     = rd_data[EW-1:KEYWORDS];
	assign rd_bm     = rd_data[KEYWORDS-1:0];
	assign rd_bm_ext = KW_W'(rd_bm);
	// keywords at or above KEYWORDS land on zero-extended bits
	assign kw_hit    = rd_bm_ext[kw_q];
	assign ptr_m1    = ptr_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		flag_d    = flag_q;
		prev_d    = prev_q;
		pend_d    = pend_q;
		id_d      = id_q;
		bm_d      = bm_q;
		kw_d      = kw_q;
		rd_en     = 1'b0;
		rd_addr   = ptr_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = addr_s1;
		wr_data   = {id_q, bm_q};
		rsp_vld_d = 1'b0;
		rsp_d     = '0;
		rsp_d.last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					id_d   = cmd.entry_id[IW-1:0];
					bm_d   = cmd.keyword_bits[KEYWORDS-1:0];
					kw_d   = cmd.keyword;
					flag_d = 1'b0;
					prev_d = 1'b0;
					ptr_d  = '0;
					case (cmd.op)
						OP_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								rsp_vld_d    = 1'b1;
								rsp_d.status = STATUS_FULL;
							end else begin
								state_d = ST_INSERT;
								ptr_d   = count_q;
							end
						end
						OP_REMOVE: state_d = ST_REMOVE;
						OP_QUERY:  state_d = ST_QUERY;
						default:   rsp_vld_d = 1'b1;
					endcase
				end
			end
			ST_INSERT: begin
				// walk down from the top, moving larger ids up one slot
				rd_en   = (ptr_q != '0);
				rd_addr = ptr_m1[AW-1:0];
				if (rd_en) begin
					ptr_d = ptr_m1;
				end
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = addr_s1 + AW'(1);
					if (rd_id > id_q) begin
						wr_data = rd_data;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (ptr_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					state_d = ST_IDLE;
				end
				if (state_d == ST_IDLE) begin
					count_d   = count_q + CW'(1);
					rsp_vld_d = 1'b1;
				end
			end
			ST_REMOVE: begin
				// the last entry of the run of equal ids is the newest one;
				// everything after it moves down one slot
				rd_en = (ptr_q != count_q);
				if (rd_en) begin
					ptr_d = ptr_q + CW'(1);
				end
				if (rd_vld_s1) begin
					prev_d = (rd_id == id_q);
					if (flag_q || (prev_q && rd_id != id_q)) begin
						wr_en   = 1'b1;
						wr_addr = addr_s1 - AW'(1);
						wr_data = rd_data;
						flag_d  = 1'b1;
					end
				end else if (!rd_en) begin
					if (flag_q || prev_q) begin
						count_d = count_q - CW'(1);
					end else begin
						rsp_d.status = STATUS_ABSENT;
					end
					rsp_vld_d = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_QUERY: begin
				// one match held back so the final one can carry last
				rd_en = (ptr_q != count_q);
				if (rd_en) begin
					ptr_d = ptr_q + CW'(1);
				end
				if (rd_vld_s1) begin
					if (kw_hit) begin
						if (flag_q) begin
							rsp_vld_d      = 1'b1;
							rsp_d.match_id = ID_W'(pend_q);
							rsp_d.found    = 1'b1;
							rsp_d.last     = 1'b0;
						end
						pend_d = rd_id;
						flag_d = 1'b1;
					end
				end else if (!rd_en) begin
					rsp_vld_d = 1'b1;
					if (flag_q) begin
						rsp_d.match_id = ID_W'(pend_q);
						rsp_d.found    = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			ptr_q          <= '0;
			flag_q         <= 1'b0;
			prev_q         <= 1'b0;
			rd_vld_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			count_q        <= count_d;
			ptr_q          <= ptr_d;
			flag_q         <= flag_d;
			prev_q         <= prev_d;
			rd_vld_s1      <= rd_en;
			result_valid_q <= rsp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q   <= pend_d;
		id_q     <= id_d;
		bm_q     <= bm_d;
		kw_q     <= kw_d;
		addr_s1  <= rd_addr;
		result_q <= rsp_d;
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[design/kbi_mem.sv]
module kbi_mem #(
	parameter int DEPTH = kbi_pkg::CAPACITY_DEF,
	parameter int WIDTH = kbi_pkg::ID_W + kbi_pkg::KW_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
